// File: rtl/bmpq_pkg.sv
`default_nettype none

package bmpq_pkg;

  // Fixed field widths of one item.
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 64;
  localparam int STATUS_W = 2;

  // Default number of entries the queue holds.
  localparam int DEFAULT_CAPACITY = 128;

  // Request kinds.
  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // One stored entry: key and payload side by side in one memory word.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } pq_entry_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_EXT_POP,
    S_RESP
  } pq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic read_head;
    logic read_prev;
    logic write_new;
    logic move_up;
    logic pop;
    logic set_full;
    logic set_empty;
    logic load_out;
  } pq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic j_zero;
    logic key_less;
    logic out_busy;
  } pq_stat_t;

endpackage

`default_nettype wire

// File: rtl/bounded_min_priority_queue_unit.sv
// Bounded minimum priority queue held as a sorted ring of entries.
// Input channel: in_valid / in_stall with in_kind, in_prio_key and
// in_payload_in. An insert stores a signed key and a 64-bit payload ahead of
// every entry whose key is greater or equal, so equal keys leave newest first.
// An extract returns the payload of the smallest key and removes it.
// Result channel: out_valid / out_stall with out_status (0 ok, 1 full on
// insert, 2 empty on extract) and out_payload_out (zero except on extract).
// Every item gives exactly one result, in order.
// Sequence: a refused insert or a refused extract goes from acceptance straight
// to the result state; an extract first reads the head entry and pops it.
// An insert scans from the tail toward the front and reads and compares each
// entry it meets until a smaller key; each moved entry costs a read and a write
// on the entry memory. The next item is accepted in the cycle after the result
// is loaded into the output register, so one item is in work at a time.
// Reset (rst_n low, synchronous) empties the queue and drops any result in the
// output register; memory contents are not cleared, and no clearing pass runs.
// While out_stall is high the result stays in the output register; an item
// already in work finishes and then waits for the register to empty.
`default_nettype none

module bounded_min_priority_queue_unit #(
  parameter int CAPACITY = bmpq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_kind,
  input  wire logic signed [bmpq_pkg::KEY_W-1:0]  in_prio_key,
  input  wire logic [bmpq_pkg::PAY_W-1:0]         in_payload_in,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [bmpq_pkg::STATUS_W-1:0]           out_status,
  output logic [bmpq_pkg::PAY_W-1:0]              out_payload_out
);
  import bmpq_pkg::*;

  pq_cmd_t  cmd;
  pq_stat_t stat;

  // Sequencer for insert scans and extracts.
  bmpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Entry memory, counters and output register.
  bmpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_prio_key     (in_prio_key),
    .in_payload_in   (in_payload_in),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_payload_out (out_payload_out)
  );

endmodule

`default_nettype wire

// File: rtl/bmpq_datapath.sv
`default_nettype none

module bmpq_datapath #(
  parameter int CAPACITY = bmpq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire bmpq_pkg::pq_cmd_t                      cmd,
  output bmpq_pkg::pq_stat_t                          stat,
  input  wire logic signed [bmpq_pkg::KEY_W-1:0]      in_prio_key,
  input  wire logic [bmpq_pkg::PAY_W-1:0]             in_payload_in,
  input  wire logic                                   out_stall,
  output logic                                        out_valid,
  output logic [bmpq_pkg::STATUS_W-1:0]               out_status,
  output logic [bmpq_pkg::PAY_W-1:0]                  out_payload_out
);
  import bmpq_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W + 1)'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

  // Entries live in a ring: logical slot j sits at physical (head + j) mod CAPACITY.
  pq_entry_t store_mem [CAPACITY];

  logic [KEY_W-1:0]    key_r;
  logic [PAY_W-1:0]    pay_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [IDX_W-1:0]    head_r;
  logic [CNT_W-1:0]    j_r;
  pq_entry_t           rd_data_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [PAY_W-1:0]    res_payload_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PAY_W-1:0]    out_payload_r;

  logic [CNT_W-1:0] j_prev;
  logic [IDX_W:0]   wr_sum;
  logic [IDX_W:0]   prev_sum;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] prev_addr;
  logic [IDX_W-1:0] rd_addr;
  pq_entry_t        wr_data;
  logic             wr_en;
  logic             rd_en;

  // Physical addresses of slot j and slot j - 1.
  always_comb begin
    j_prev   = j_r - 1'b1;
    wr_sum   = {1'b0, head_r} + {1'b0, j_r[IDX_W-1:0]};
    prev_sum = {1'b0, head_r} + {1'b0, j_prev[IDX_W-1:0]};
    if (wr_sum >= CAP_SUM) begin
      wr_sum = wr_sum - CAP_SUM;
    end
    if (prev_sum >= CAP_SUM) begin
      prev_sum = prev_sum - CAP_SUM;
    end
    wr_addr   = wr_sum[IDX_W-1:0];
    prev_addr = prev_sum[IDX_W-1:0];
    rd_addr   = cmd.read_head ? head_r : prev_addr;
    rd_en     = cmd.read_head | cmd.read_prev;
    wr_en     = cmd.write_new | cmd.move_up;
    if (cmd.write_new) begin
      wr_data = '{key: key_r, payload: pay_r};
    end else begin
      wr_data = rd_data_r;
    end
  end

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // Request capture and the scan position.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      key_r <= in_prio_key;
      pay_r <= in_payload_in;
      j_r   <= cnt_r;
    end else if (cmd.move_up) begin
      j_r <= j_prev;
    end
  end

  // Fill count and ring head.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      head_r <= '0;
    end else if (cmd.write_new) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.pop) begin
      cnt_r  <= cnt_r - 1'b1;
      head_r <= (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    end
  end

  // Pending result of the item in work.
  always_ff @(posedge clk) begin
    if (cmd.set_full) begin
      res_status_r  <= STATUS_FULL;
      res_payload_r <= '0;
    end else if (cmd.set_empty) begin
      res_status_r  <= STATUS_EMPTY;
      res_payload_r <= '0;
    end else if (cmd.write_new) begin
      res_status_r  <= STATUS_OK;
      res_payload_r <= '0;
    end else if (cmd.pop) begin
      res_status_r  <= STATUS_OK;
      res_payload_r <= rd_data_r.payload;
    end
  end

  // Output register that holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r  <= res_status_r;
      out_payload_r <= res_payload_r;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.full     = (cnt_r == CAP_CNT);
    stat.empty    = (cnt_r == '0);
    stat.j_zero   = (j_r == '0);
    stat.key_less = $signed(rd_data_r.key) < $signed(key_r);
    stat.out_busy = out_valid_r & out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_payload_out = out_payload_r;

endmodule

`default_nettype wire

// File: rtl/bmpq_ctrl.sv
`default_nettype none

module bmpq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_kind,
  output logic                     in_stall,
  input  wire bmpq_pkg::pq_stat_t  stat,
  output bmpq_pkg::pq_cmd_t        cmd
);
  import bmpq_pkg::*;

  pq_state_t state_r;
  pq_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_INSERT) begin
            state_nxt = stat.full ? S_RESP : S_INS_RD;
          end else begin
            state_nxt = stat.empty ? S_RESP : S_EXT_POP;
          end
        end
      end
      S_INS_RD: begin
        state_nxt = stat.j_zero ? S_RESP : S_INS_CMP;
      end
      S_INS_CMP: begin
        state_nxt = stat.key_less ? S_RESP : S_INS_RD;
      end
      S_EXT_POP: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          if (in_kind == KIND_INSERT) begin
            cmd.set_full = stat.full;
          end else begin
            cmd.set_empty = stat.empty;
            cmd.read_head = ~stat.empty;
          end
        end
      end
      S_INS_RD: begin
        // Slot zero reached: the new entry goes to the front.
        cmd.write_new = stat.j_zero;
        cmd.read_prev = ~stat.j_zero;
      end
      S_INS_CMP: begin
        // Stop at the first smaller key, otherwise shift that entry up by one.
        cmd.write_new = stat.key_less;
        cmd.move_up   = ~stat.key_less;
      end
      S_EXT_POP: begin
        cmd.pop = 1'b1;
      end
      S_RESP: begin
        cmd.load_out = ~stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/bmpq_chk.sv
`default_nettype none

module bmpq_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [bmpq_pkg::STATUS_W-1:0]     out_status,
  input wire logic [bmpq_pkg::PAY_W-1:0]        out_payload_out
);
  import bmpq_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_payload_out))
    else $error("stalled result changed");

  // A refused insert or extract carries a zero payload.
  a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_payload_out == '0)
    else $error("nonzero payload on a refused item");

  // Status is one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_FULL ||
                   out_status == STATUS_EMPTY))
    else $error("undefined status code");

  // One item in work at a time: an accepted item stalls the input next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while one is in work");

  // Reset drops any waiting result.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bounded_min_priority_queue_unit bmpq_chk u_bmpq_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_payload_out (out_payload_out)
);

`default_nettype wire
